### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros: clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define CHK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define CHK_NEVER(label, clk, rst_n, expr) \
    `CHK_ASSERT(label, clk, rst_n, !(expr))

`endif

### rtl/core/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg
// Types and constants shared by the cartridge bank controller modules.
// ----------------------------------------------------------------------------
package cbc_pkg;

    // Controller types; codes 6 and 7 act as no controller
    typedef enum logic [2:0] {
        CT_NONE = 3'd0,
        CT_MBC1 = 3'd1,
        CT_MBC2 = 3'd2,
        CT_MBC3 = 3'd3,
        CT_MBC5 = 3'd4,
        CT_HUC1 = 3'd5
    } t_ctrl;

    // Configuration register indexes
    localparam logic [2:0] CFG_CTRL_TYPE  = 3'd0;
    localparam logic [2:0] CFG_ROM_COUNT  = 3'd1;
    localparam logic [2:0] CFG_RAM_COUNT  = 3'd2;
    localparam logic [2:0] CFG_RAM_FITTED = 3'd3;
    localparam logic [2:0] CFG_CLK_FITTED = 3'd4;
    localparam logic [2:0] CFG_RUMBLE     = 3'd5;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 9;

    // Remainder unit: dividend and divisor widths, one bit per step
    localparam int unsigned BANK_W    = 9;
    localparam int unsigned MOD_STEPS = BANK_W;
    localparam int unsigned STEP_W    = $clog2(MOD_STEPS);

    localparam logic [3:0] RAM_EN_KEY   = 4'hA;
    localparam logic [3:0] CLK_SEL_BASE = 4'h8;

    typedef struct packed {
        logic [14:0] write_address;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] rom_bank;
        logic [3:0] ram_bank;
        logic       ram_enabled;
        logic       clock_selected;
        logic       rejected;
    } t_out_item;

    typedef struct packed {
        logic [2:0] ctrl_type;
        logic       clock_fitted;
        logic       rumble_fitted;
    } t_dec_cfg;

    typedef struct packed {
        logic [7:0] low_select;
        logic [3:0] high_select;
        logic [3:0] ram_select;
        logic       banking_mode;
        logic       ram_enable;
    } t_latches;

    typedef struct packed {
        t_latches          latch;
        logic [BANK_W-1:0] raw_rom;
        logic [3:0]        raw_ram;
        logic              recompute;
        logic              rejected;
    } t_dec_out;

    typedef struct packed {
        logic              start;
        logic [BANK_W-1:0] dividend;
        logic [BANK_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic              done;
        logic [BANK_W-1:0] remainder;
    } t_mod_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROM,
        ST_RAM,
        ST_OUT
    } t_state;

endpackage

### rtl/core/cbc_decode.sv
// ----------------------------------------------------------------------------
// cbc_decode
// Decodes one control-area write into new latch values, the unreduced
// ROM/RAM bank numbers and the recompute / reject flags.
// ----------------------------------------------------------------------------
module cbc_decode import cbc_pkg::*; (
    input  t_in_item   i_item,
    input  t_dec_cfg   i_cfg,
    input  t_latches   i_latch,
    input  logic [7:0] i_cur_rom,
    input  logic [3:0] i_cur_ram,
    output t_dec_out   o_dec
);

    logic [2:0] area;
    logic [7:0] data;
    logic       bit8;
    logic       en_hit;
    t_latches   nl;
    logic       recompute;
    logic       rejected;
    logic [BANK_W-1:0] raw_rom;
    logic [3:0] raw_ram;
    logic [4:0] low5;
    logic [6:0] low7;

    assign area   = i_item.write_address[14:12];
    assign bit8   = i_item.write_address[8];
    assign data   = i_item.write_data;
    assign en_hit = (data[3:0] == RAM_EN_KEY);

    // Latch updates
    always_comb begin
        nl        = i_latch;
        recompute = 1'b0;
        rejected  = 1'b0;
        unique case (i_cfg.ctrl_type)
            CT_MBC1, CT_HUC1: begin
                if (area[2:1] == 2'd0) begin
                    nl.ram_enable = en_hit;
                end else if (area[2:1] == 2'd1) begin
                    nl.low_select = {3'd0, data[4:0]};
                    recompute     = 1'b1;
                end else if (area[2:1] == 2'd2) begin
                    nl.high_select = {2'd0, data[1:0]};
                    recompute      = 1'b1;
                end else begin
                    nl.banking_mode = data[0];
                    recompute       = 1'b1;
                end
            end
            CT_MBC2: begin
                if (area[2:1] == 2'd0) begin
                    if (!bit8) nl.ram_enable = en_hit;
                end else if (area[2:1] == 2'd1) begin
                    if (bit8) begin
                        nl.low_select = {4'd0, data[3:0]};
                        recompute     = 1'b1;
                    end
                end else begin
                    rejected = 1'b1;
                end
            end
            CT_MBC3: begin
                if (area[2:1] == 2'd0) begin
                    nl.ram_enable = en_hit;
                end else if (area[2:1] == 2'd1) begin
                    nl.low_select = {1'b0, data[6:0]};
                    recompute     = 1'b1;
                end else if (area[2:1] == 2'd2) begin
                    nl.high_select = data[3:0];
                    recompute      = 1'b1;
                end else if (i_cfg.clock_fitted) begin
                    // mode write here only latches, banks stay as they are
                    nl.banking_mode = data[0];
                end
            end
            CT_MBC5: begin
                if (area[2:1] == 2'd0) begin
                    nl.ram_enable = en_hit;
                end else if (area == 3'd2) begin
                    nl.low_select = data;
                    recompute     = 1'b1;
                end else if (area == 3'd3) begin
                    nl.high_select = {3'd0, data[0]};
                    recompute      = 1'b1;
                end else if (area[2:1] == 2'd2) begin
                    nl.ram_select = data[3:0];
                    recompute     = 1'b1;
                end else begin
                    rejected = 1'b1;
                end
            end
            default: begin
                rejected = 1'b1;
            end
        endcase
    end

    assign low5 = nl.low_select[4:0];
    assign low7 = nl.low_select[6:0];

    // Unreduced bank numbers from the updated latches
    always_comb begin
        raw_rom = {1'b0, i_cur_rom};
        raw_ram = i_cur_ram;
        unique case (i_cfg.ctrl_type)
            CT_MBC1, CT_HUC1: begin
                if (nl.banking_mode) begin
                    raw_ram = {2'd0, nl.high_select[1:0]};
                    raw_rom = (low5 == 5'd0) ? BANK_W'(1) : BANK_W'(low5);
                end else begin
                    raw_ram = 4'd0;
                    raw_rom = BANK_W'({nl.high_select[1:0], low5})
                            + BANK_W'(low5 == 5'd0);
                end
            end
            CT_MBC2: begin
                raw_rom = (nl.low_select[3:0] == 4'd0) ? BANK_W'(1)
                                                      : BANK_W'(nl.low_select[3:0]);
            end
            CT_MBC3: begin
                // RAM bank holds while the clock registers are selected
                if (!i_cfg.clock_fitted || nl.high_select < CLK_SEL_BASE) begin
                    raw_ram = {2'd0, nl.high_select[1:0]};
                end
                raw_rom = (low7 == 7'd0) ? BANK_W'(1) : BANK_W'(low7);
            end
            CT_MBC5: begin
                raw_rom = {nl.high_select[0], nl.low_select};
                raw_ram = i_cfg.rumble_fitted ? {1'b0, nl.ram_select[2:0]}
                                              : nl.ram_select;
            end
            default: begin
                raw_rom = {1'b0, i_cur_rom};
            end
        endcase
    end

    assign o_dec.latch     = nl;
    assign o_dec.raw_rom   = raw_rom;
    assign o_dec.raw_ram   = raw_ram;
    assign o_dec.recompute = recompute;
    assign o_dec.rejected  = rejected;

endmodule

### rtl/core/cbc_mod.sv
// ----------------------------------------------------------------------------
// cbc_mod
// Shared restoring remainder unit, one dividend bit per cycle.
// A zero divisor returns the dividend unchanged.
// ----------------------------------------------------------------------------
module cbc_mod import cbc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mod_req i_req,
    output t_mod_rsp o_rsp
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [BANK_W-1:0] r_rem, n_rem;
    logic [BANK_W-1:0] r_dvd, n_dvd;
    logic [BANK_W-1:0] r_div, n_div;
    logic [BANK_W:0]   trial;

    assign trial = {r_rem, r_dvd[BANK_W-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvd  = i_req.dividend;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                n_rem = BANK_W'(trial - {1'b0, r_div});
            end else begin
                n_rem = trial[BANK_W-1:0];
            end
            n_dvd = {r_dvd[BANK_W-2:0], 1'b0};
            n_cnt = r_cnt + STEP_W'(1);
            if (r_cnt == STEP_W'(MOD_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_div <= n_div;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem;

endmodule

### rtl/core/cartridge_bank_controller_core.sv
// ----------------------------------------------------------------------------
// cartridge_bank_controller_core
// Bank controller for a handheld game cartridge (MBC1/MBC2/MBC3/MBC5/HuC1).
// Each input item is one CPU write into the 0x0000-0x7FFF control area; one
// result item follows with the current ROM and RAM bank, the RAM enable
// latch, the clock-select flag and a reject flag. Writes that select a bank
// run the new ROM and then RAM bank through one shared bit-serial remainder
// unit, nine steps each, to reduce them by the configured bank counts;
// enable writes, ignored and rejected writes show theirs in the next cycle.
// The input reopens the cycle after the result is taken. One item is in
// flight at a time; configuration writes are accepted at any cycle and
// belong in idle time.
// ----------------------------------------------------------------------------
module cartridge_bank_controller_core import cbc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state     r_state, n_state;

    logic [2:0] r_ctrl_type;
    logic [8:0] r_rom_count;
    logic [4:0] r_ram_count;
    logic       r_ram_fitted;
    logic       r_clk_fitted;
    logic       r_rumble;

    t_latches   r_latch;
    logic [7:0] r_cur_rom;
    logic [3:0] r_cur_ram;
    logic [3:0] r_raw_ram;
    logic       r_rejected;

    t_dec_cfg   dec_cfg;
    t_dec_out   dec;
    t_mod_req   mod_req;
    t_mod_rsp   mod_rsp;
    logic       in_acc;
    logic       out_acc;
    logic       cfg_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;

    assign dec_cfg.ctrl_type     = r_ctrl_type;
    assign dec_cfg.clock_fitted  = r_clk_fitted;
    assign dec_cfg.rumble_fitted = r_rumble;

    cbc_decode u_decode (
        .i_item    (i_in_item),
        .i_cfg     (dec_cfg),
        .i_latch   (r_latch),
        .i_cur_rom (r_cur_rom),
        .i_cur_ram (r_cur_ram),
        .o_dec     (dec)
    );

    cbc_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc) n_state = dec.recompute ? ST_ROM : ST_OUT;
            ST_ROM:  if (mod_rsp.done) n_state = ST_RAM;
            ST_RAM:  if (mod_rsp.done) n_state = ST_OUT;
            ST_OUT:  if (i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs; a zero divisor passes the bank through unreduced
    always_comb begin
        o_in_ready       = 1'b0;
        o_out_valid      = 1'b0;
        mod_req.start    = 1'b0;
        mod_req.dividend = dec.raw_rom;
        mod_req.divisor  = r_rom_count;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                mod_req.start = in_acc && dec.recompute;
            end
            ST_ROM: begin
                mod_req.start    = mod_rsp.done;
                mod_req.dividend = BANK_W'(r_raw_ram);
                mod_req.divisor  = r_ram_fitted ? BANK_W'(r_ram_count) : '0;
            end
            ST_RAM: begin
                mod_req.start = 1'b0;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ctrl_type  <= CT_NONE;
            r_rom_count  <= 9'd2;
            r_ram_count  <= 5'd1;
            r_ram_fitted <= 1'b0;
            r_clk_fitted <= 1'b0;
            r_rumble     <= 1'b0;
            r_latch      <= '0;
            r_cur_rom    <= 8'd1;
            r_cur_ram    <= 4'd0;
            r_rejected   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    CFG_CTRL_TYPE:  r_ctrl_type  <= i_cfg_data[2:0];
                    CFG_ROM_COUNT:  r_rom_count  <= i_cfg_data;
                    CFG_RAM_COUNT:  r_ram_count  <= i_cfg_data[4:0];
                    CFG_RAM_FITTED: r_ram_fitted <= i_cfg_data[0];
                    CFG_CLK_FITTED: r_clk_fitted <= i_cfg_data[0];
                    CFG_RUMBLE:     r_rumble     <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_latch    <= dec.latch;
                r_rejected <= dec.rejected;
            end
            if (mod_rsp.done && r_state == ST_ROM) begin
                r_cur_rom <= mod_rsp.remainder[7:0];
            end
            if (mod_rsp.done && r_state == ST_RAM) begin
                r_cur_ram <= mod_rsp.remainder[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) r_raw_ram <= dec.raw_ram;
    end

    assign o_out_item.rom_bank       = r_cur_rom;
    assign o_out_item.ram_bank       = r_cur_ram;
    assign o_out_item.ram_enabled    = r_latch.ram_enable;
    assign o_out_item.clock_selected = r_clk_fitted
                                    && (r_latch.high_select >= CLK_SEL_BASE);
    assign o_out_item.rejected       = r_rejected;

endmodule

### rtl/core/cbc_checker.sv
// ----------------------------------------------------------------------------
// cbc_port_checker
// Port-level checks for the bank controller core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbc_port_checker import cbc_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_item             o_out_item
);

    // an accepted item blocks the input until its result is delivered
    `CHK_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready)
    // never a pending result and an open input at once
    `CHK_NEVER(a_one_in_flight, i_clk, i_rst_n, o_out_valid && o_in_ready)
    // a result is delivered once
    `CHK_ASSERT(a_single_result, i_clk, i_rst_n, (o_out_valid && i_out_ready) |=> !o_out_valid)
    // stalled result holds
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))

endmodule

bind cartridge_bank_controller_core cbc_port_checker u_cbc_checker (.*);

### tb/cbc_checker.sv
// ----------------------------------------------------------------------------
// cbc_checker
// Watches the write, result and configuration channels of the cartridge bank
// controller. It keeps its own copy of the bank latches and the configuration,
// predicts the result of every accepted write, and compares each accepted
// result field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module cbc_checker import cbc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_item,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    // configuration copy
    logic [2:0] cf_type;
    logic [8:0] cf_rom_cnt;
    logic [4:0] cf_ram_cnt;
    logic       cf_ram_fit;
    logic       cf_clk_fit;
    logic       cf_rumble;

    // bank latches
    logic [7:0] lo_sel;
    logic [3:0] hi_sel;
    logic [3:0] ram_sel;
    logic       mode_bit;
    logic       ram_en;
    logic [7:0] cur_rom;
    logic [3:0] cur_ram;

    t_out_item  pending_banks[$];
    int         mismatch_count = 0;

    // New ROM/RAM bank after a bank-select or mode write
    function automatic void rebank();
        logic [8:0] rom;
        logic [3:0] ram;
        rom = {1'b0, cur_rom};
        ram = cur_ram;
        case (cf_type)
            CT_MBC1, CT_HUC1: begin
                if (mode_bit) begin
                    ram = {2'b0, hi_sel[1:0]};
                    rom = {4'b0, lo_sel[4:0]};
                    if (rom == 9'd0) rom = 9'd1;
                end else begin
                    ram = 4'd0;
                    rom = {2'b0, hi_sel[1:0], lo_sel[4:0]};
                    if (lo_sel[4:0] == 5'd0) rom = rom + 9'd1;
                end
            end
            CT_MBC2: begin
                rom = {5'b0, lo_sel[3:0]};
                if (rom == 9'd0) rom = 9'd1;
            end
            CT_MBC3: begin
                // RAM bank frozen while a clock register is selected
                if (!cf_clk_fit || hi_sel < CLK_SEL_BASE) ram = {2'b0, hi_sel[1:0]};
                rom = {2'b0, lo_sel[6:0]};
                if (rom == 9'd0) rom = 9'd1;
            end
            CT_MBC5: begin
                rom = {hi_sel[0], lo_sel};
                ram = cf_rumble ? {1'b0, ram_sel[2:0]} : ram_sel;
            end
            default: ;
        endcase
        if (cf_rom_cnt != 9'd0) rom = rom % cf_rom_cnt;
        if (cf_ram_fit && cf_ram_cnt != 5'd0) ram = 4'({1'b0, ram} % cf_ram_cnt);
        cur_rom = rom[7:0];
        cur_ram = ram;
    endfunction

    function automatic t_out_item bank_write(t_in_item it);
        logic [2:0] area;
        logic       a8;
        logic [7:0] d;
        t_out_item  res;
        area = it.write_address[14:12];
        a8   = it.write_address[8];
        d    = it.write_data;
        res.rejected = 1'b0;
        case (cf_type)
            CT_MBC1, CT_HUC1: begin
                if (area < 3'd2) ram_en = (d[3:0] == RAM_EN_KEY);
                else if (area < 3'd4) begin
                    lo_sel = {3'b0, d[4:0]};
                    rebank();
                end else if (area < 3'd6) begin
                    hi_sel = {2'b0, d[1:0]};
                    rebank();
                end else begin
                    mode_bit = d[0];
                    rebank();
                end
            end
            CT_MBC2: begin
                if (area < 3'd2) begin
                    if (!a8) ram_en = (d[3:0] == RAM_EN_KEY);
                end else if (area < 3'd4) begin
                    if (a8) begin
                        lo_sel = {4'b0, d[3:0]};
                        rebank();
                    end
                end else res.rejected = 1'b1;
            end
            CT_MBC3: begin
                if (area < 3'd2) ram_en = (d[3:0] == RAM_EN_KEY);
                else if (area < 3'd4) begin
                    lo_sel = {1'b0, d[6:0]};
                    rebank();
                end else if (area < 3'd6) begin
                    hi_sel = d[3:0];
                    rebank();
                end else if (cf_clk_fit) mode_bit = d[0];
            end
            CT_MBC5: begin
                if (area < 3'd2) ram_en = (d[3:0] == RAM_EN_KEY);
                else if (area == 3'd2) begin
                    lo_sel = d;
                    rebank();
                end else if (area == 3'd3) begin
                    hi_sel = {3'b0, d[0]};
                    rebank();
                end else if (area < 3'd6) begin
                    ram_sel = d[3:0];
                    rebank();
                end else res.rejected = 1'b1;
            end
            default: res.rejected = 1'b1;
        endcase
        res.rom_bank       = cur_rom;
        res.ram_bank       = cur_ram;
        res.ram_enabled    = ram_en;
        res.clock_selected = cf_clk_fit && (hi_sel >= CLK_SEL_BASE);
        return res;
    endfunction

    task automatic report_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            cf_type    = CT_NONE;
            cf_rom_cnt = 9'd2;
            cf_ram_cnt = 5'd1;
            cf_ram_fit = 1'b0;
            cf_clk_fit = 1'b0;
            cf_rumble  = 1'b0;
            lo_sel     = '0;
            hi_sel     = '0;
            ram_sel    = '0;
            mode_bit   = 1'b0;
            ram_en     = 1'b0;
            cur_rom    = 8'd1;
            cur_ram    = '0;
            pending_banks.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CTRL_TYPE:  cf_type    = i_cfg_data[2:0];
                    CFG_ROM_COUNT:  cf_rom_cnt = i_cfg_data[8:0];
                    CFG_RAM_COUNT:  cf_ram_cnt = i_cfg_data[4:0];
                    CFG_RAM_FITTED: cf_ram_fit = i_cfg_data[0];
                    CFG_CLK_FITTED: cf_clk_fit = i_cfg_data[0];
                    CFG_RUMBLE:     cf_rumble  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_banks.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_out_item);
                    mismatch_count++;
                end else begin
                    want = pending_banks.pop_front();
                    report_field("rom_bank", 32'(want.rom_bank), 32'(i_out_item.rom_bank));
                    report_field("ram_bank", 32'(want.ram_bank), 32'(i_out_item.ram_bank));
                    report_field("ram_enabled", 32'(want.ram_enabled),
                                 32'(i_out_item.ram_enabled));
                    report_field("clock_selected", 32'(want.clock_selected),
                                 32'(i_out_item.clock_selected));
                    report_field("rejected", 32'(want.rejected), 32'(i_out_item.rejected));
                end
            end
            if (i_in_valid && i_in_ready) pending_banks.push_back(bank_write(i_in_item));
        end
        o_errors  <= mismatch_count;
        o_pending <= pending_banks.size();
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the cartridge bank controller: a short directed run over every
// controller type but HuC1 and the corner cases of the bank counts, then random
// control writes over many configurations with random gaps on both handshakes
// and one long hold-off on the result side. Checking is done by cbc_checker.
// ----------------------------------------------------------------------------
module tb;
    import cbc_pkg::*;

    localparam logic [2:0] CT_UNDEF_LO = 3'd6;
    localparam logic [2:0] CT_UNDEF_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int N_PHASES        = 12;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int HOLD_CYCLES     = 400;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    errors;
    int                    pending;
    logic                  stall_req = 1'b0;

    cartridge_bank_controller_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    cbc_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #16_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: ready stretches, short and long stalls, one long hold-off
    initial begin : rx_proc
        int  run_left;
        int  r;
        logic lvl;
        run_left = 0;
        lvl      = 1'b1;
        forever begin
            @(posedge clk);
            if (stall_req) begin
                stall_req = 1'b0;
                lvl       = 1'b0;
                run_left  = HOLD_CYCLES;
            end else if (run_left <= 0) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    lvl      = 1'b1;
                    run_left = $urandom_range(1, 30);
                end else if (r < 95) begin
                    lvl      = 1'b0;
                    run_left = $urandom_range(1, 3);
                end else begin
                    lvl      = 1'b0;
                    run_left = $urandom_range(20, 40);
                end
            end
            out_ready <= lvl;
            run_left--;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // unused upper data bits carry noise
    task automatic set_config(input logic [2:0] ct, input logic [8:0] rom_n,
                              input logic [4:0] ram_n, input logic rf,
                              input logic cf, input logic rb);
        logic [8:0] junk;
        junk = 9'($urandom);
        cfg_write(CFG_CTRL_TYPE, {junk[8:3], ct});
        cfg_write(CFG_ROM_COUNT, rom_n);
        cfg_write(CFG_RAM_COUNT, {junk[7:4], ram_n});
        cfg_write(CFG_RAM_FITTED, {junk[7:0], rf});
        cfg_write(CFG_CLK_FITTED, {junk[8:1], cf});
        cfg_write(CFG_RUMBLE, {~junk[7:0], rb});
    endtask

    // leaves valid high after the accept; the caller lowers it at phase end
    task automatic send_item(input logic [14:0] addr, input logic [7:0] data,
                             input bit no_gap);
        int gap;
        int r;
        gap = 0;
        if (!no_gap) begin
            r = $urandom_range(0, 99);
            if (r >= 95) gap = $urandom_range(20, 40);
            else if (r >= 70) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= {addr, data};
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic end_phase();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    initial begin : stim
        logic [2:0]  ct;
        logic [8:0]  rom_n;
        logic [4:0]  ram_n;
        logic [14:0] addr;
        logic [7:0]  data;
        int          sel;
        int          n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no controller after reset: all rejected
        send_item(15'h0000, 8'h0A, 1'b0);
        send_item(15'h7FFF, 8'hFF, 1'b0);
        end_phase();

        // MBC1 with zero ROM count, mode switching
        set_config(CT_MBC1, 9'd0, 5'd4, 1'b1, 1'b1, 1'b1);
        send_item(15'h1000, 8'h5A, 1'b0);
        send_item(15'h2000, 8'h00, 1'b0);
        send_item(15'h4000, 8'h03, 1'b0);
        send_item(15'h6000, 8'h01, 1'b0);
        send_item(15'h7FFF, 8'h00, 1'b0);
        end_phase();

        // MBC2: address bit 8 must be clear for enable and set for bank, upper half rejected
        set_config(CT_MBC2, 9'd5, 5'd4, 1'b1, 1'b0, 1'b0);
        send_item(15'h0000, 8'h0A, 1'b0);
        send_item(15'h0100, 8'h00, 1'b0);
        send_item(15'h2100, 8'h0F, 1'b0);
        send_item(15'h2000, 8'h07, 1'b0);
        send_item(15'h5000, 8'h11, 1'b0);
        end_phase();

        // MBC3 with clock, RAM not fitted
        set_config(CT_MBC3, 9'd5, 5'd3, 1'b0, 1'b1, 1'b0);
        send_item(15'h2000, 8'h7F, 1'b0);
        send_item(15'h4000, 8'h0C, 1'b0);
        send_item(15'h6000, 8'h01, 1'b0);
        send_item(15'h4000, 8'h03, 1'b0);
        end_phase();

        // MBC5 with rumble and a ROM count past the bank range
        set_config(CT_MBC5, 9'd511, 5'd16, 1'b1, 1'b0, 1'b1);
        send_item(15'h2000, 8'hFF, 1'b0);
        send_item(15'h3000, 8'h01, 1'b0);
        send_item(15'h4000, 8'h0F, 1'b0);
        send_item(15'h6000, 8'h00, 1'b0);
        end_phase();

        // undefined controller codes and unused register indexes
        set_config(CT_UNDEF_HI, 9'd300, 5'd31, 1'b1, 1'b1, 1'b0);
        cfg_write(CFG_SPARE_LO, '1);
        cfg_write(CFG_SPARE_HI, 9'h0A5);
        send_item(15'h2000, 8'h01, 1'b0);
        end_phase();
        cfg_write(CFG_CTRL_TYPE, {6'b0, CT_UNDEF_LO});
        send_item(15'h4000, 8'h02, 1'b0);
        end_phase();

        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 0) begin
                ct = CT_MBC5; rom_n = 9'd256; ram_n = 5'd16;
                set_config(ct, rom_n, ram_n, 1'b1, 1'b1, 1'b1);
            end else if (p == 1) begin
                ct = CT_MBC1; rom_n = 9'd2; ram_n = 5'd1;
                set_config(ct, rom_n, ram_n, 1'b0, 1'b0, 1'b0);
            end else begin
                sel = $urandom_range(0, 19);
                if (sel == 0) ct = CT_NONE;
                else if (sel == 1) ct = ($urandom_range(0, 1) != 0) ? CT_UNDEF_LO : CT_UNDEF_HI;
                else ct = t_ctrl'($urandom_range(CT_MBC1, CT_HUC1));
                sel = $urandom_range(0, 9);
                if (sel == 0) rom_n = 9'd0;
                else if (sel == 1) rom_n = 9'd2;
                else if (sel == 2) rom_n = 9'd256;
                else if (sel == 3) rom_n = 9'($urandom_range(257, 511));
                else rom_n = 9'($urandom_range(1, 256));
                sel = $urandom_range(0, 9);
                if (sel == 0) ram_n = 5'd0;
                else if (sel == 1) ram_n = 5'd1;
                else if (sel == 2) ram_n = 5'd16;
                else if (sel == 3) ram_n = 5'($urandom_range(17, 31));
                else ram_n = 5'($urandom_range(1, 16));
                set_config(ct, rom_n, ram_n, 1'($urandom), 1'($urandom), 1'($urandom));
            end
            if (p == 2) stall_req = 1'b1;
            n = (ct == CT_NONE || ct == CT_UNDEF_LO || ct == CT_UNDEF_HI) ?
                20 : ITEMS_PER_PHASE;
            for (int k = 0; k < n; k++) begin
                addr = 15'($urandom);
                data = 8'($urandom);
                sel  = $urandom_range(0, 9);
                // favor the enable key in the enable area, and bank zero
                if (sel < 3 && addr[14:13] == 2'b00) data[3:0] = RAM_EN_KEY;
                else if (sel == 3) data = '0;
                send_item(addr, data, (p % 4) == 3);
            end
            end_phase();
        end

        repeat (30) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
